[sv/steering_force_feedback_mixer_unit_assert.svh]
// Assertion macros for the steering force feedback mixer.
`ifndef STEERING_FORCE_FEEDBACK_MIXER_UNIT_ASSERT_SVH
`define STEERING_FORCE_FEEDBACK_MIXER_UNIT_ASSERT_SVH

// Checks that a condition implies a consequence on the same clock edge.
`define SFFM_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Checks that a condition implies a consequence on the next clock edge.
`define SFFM_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

[sv/sffm_pkg.sv]
package sffm_pkg;

  localparam logic [16:0] SOFT_LOCK_WEIGHT = 17'd27853;
  localparam logic [16:0] ENGINE_WEIGHT = 17'd0;

  // Configuration register indexes.
  localparam logic [2:0] REG_GAIN = 3'd0;
  localparam logic [2:0] REG_CENTER = 3'd1;
  localparam logic [2:0] REG_SLIDE = 3'd2;
  localparam logic [2:0] REG_COLL = 3'd3;
  localparam logic [2:0] REG_ROAD = 3'd4;
  localparam logic [2:0] REG_DAMP = 3'd5;
  localparam logic [2:0] REG_MINF = 3'd6;
  localparam logic [2:0] REG_MODE = 3'd7;

  // Datapath operations, one per sequencer step.
  typedef enum logic [4:0] {
    OP_LOAD,
    OP_LIGHT,
    OP_GRIP,
    OP_C1,
    OP_C2,
    OP_C3,
    OP_COLL,
    OP_ROAD1,
    OP_ROAD2,
    OP_ROAD3,
    OP_DAMP,
    OP_SOFT,
    OP_ENG1,
    OP_ENG2,
    OP_SUM,
    OP_CLIPSET,
    OP_DIV,
    OP_CLIPEND,
    OP_GAIN,
    OP_TARGET,
    OP_LOW1,
    OP_LOW2,
    OP_LOW3,
    OP_HIGH1,
    OP_HIGH2,
    OP_HIGH3,
    OP_SMOOTH,
    OP_IDLE
  } op_t;

  typedef struct packed {
    op_t op;
  } sffm_cmd_t;

  typedef struct packed {
    logic div_done;
  } sffm_stat_t;

  // Caps an unsigned Q0.15 weight at one.
  function automatic logic [16:0] unit_w(input logic [15:0] w);
    return (w > 16'd32768) ? 17'd32768 : {1'b0, w};
  endfunction

  // Signed value times Q0.15 weight, truncated toward zero.
  function automatic logic signed [19:0] mulq(input logic signed [19:0] a,
                                               input logic [16:0] w);
    logic [19:0] mag;
    logic [36:0] prod;
    logic [19:0] m;
    mag = a[19] ? 20'(-a) : a;
    prod = mag * w;
    m = prod[34:15];
    return a[19] ? -$signed(m) : $signed(m);
  endfunction

  // Clamps to plus or minus one.
  function automatic logic signed [19:0] clamp_s(input logic signed [25:0] v);
    if (v > 26'sd32768) return 20'sd32768;
    if (v < -26'sd32768) return -20'sd32768;
    return 20'(v);
  endfunction

  // Clamps to zero through one.
  function automatic logic signed [19:0] clamp_u(input logic signed [23:0] v);
    if (v < 24'sd0) return 20'sd0;
    if (v > 24'sd32768) return 20'sd32768;
    return 20'(v);
  endfunction

endpackage

[sv/sffm_stream_if.sv]
interface sffm_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] steer_position;
  logic signed [15:0] vehicle_speed;
  logic signed [15:0] load_angle;
  logic grip_lost;
  logic signed [15:0] collision_push;
  logic signed [15:0] road_bump;
  logic signed [15:0] cross_slope;
  logic signed [15:0] wheel_axis;
  logic signed [15:0] prior_wheel_axis;
  logic signed [15:0] engine_wave;
  logic car_active;
  modport source (output valid, steer_position, vehicle_speed, load_angle, grip_lost,
                  collision_push, road_bump, cross_slope, wheel_axis, prior_wheel_axis,
                  engine_wave, car_active, input ready);
  modport sink (input valid, steer_position, vehicle_speed, load_angle, grip_lost,
                collision_push, road_bump, cross_slope, wheel_axis, prior_wheel_axis,
                engine_wave, car_active, output ready);
endinterface

interface sffm_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] torque;
  logic [15:0] low_rumble;
  logic [15:0] high_rumble;
  modport source (output valid, torque, low_rumble, high_rumble, input ready);
  modport sink (input valid, torque, low_rumble, high_rumble, output ready);
endinterface

interface sffm_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/sffm_ctrl.sv]
module sffm_ctrl import sffm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  sffm_stat_t stat,
  output sffm_cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DIV, S_OUT} state_t;

  state_t state;
  op_t op;

  // Output register frees once taken, so a new transaction may enter then.
  assign in_ready = (state == S_IDLE) || (state == S_OUT && out_ready);
  assign cmd.op = (state == S_IDLE || state == S_OUT) ?
                  ((in_valid && in_ready) ? OP_LOAD : OP_IDLE) : op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= OP_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE, S_OUT: begin
          if (state == S_OUT && out_ready) out_valid <= 1'b0;
          if (in_valid && in_ready) begin
            state <= S_RUN;
            op <= OP_LIGHT;
          end else if (state == S_OUT && out_ready) begin
            state <= S_IDLE;
          end
        end
        S_RUN: begin
          if (op == OP_CLIPSET) begin
            state <= S_DIV;
            op <= OP_DIV;
          end else if (op == OP_SMOOTH) begin
            state <= S_OUT;
            op <= OP_IDLE;
            out_valid <= 1'b1;
          end else begin
            op <= op_t'(op + 5'd1);
          end
        end
        S_DIV: begin
          if (stat.div_done) begin
            state <= S_RUN;
            op <= OP_CLIPEND;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/sffm_datapath.sv]
module sffm_datapath import sffm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  sffm_cmd_t         cmd,
  output sffm_stat_t        stat,
  input  logic signed [15:0] steer_position,
  input  logic signed [15:0] vehicle_speed,
  input  logic signed [15:0] load_angle,
  input  logic              grip_lost,
  input  logic signed [15:0] collision_push,
  input  logic signed [15:0] road_bump,
  input  logic signed [15:0] cross_slope,
  input  logic signed [15:0] wheel_axis,
  input  logic signed [15:0] prior_wheel_axis,
  input  logic signed [15:0] engine_wave,
  input  logic              car_active,
  input  logic [15:0]       regs [8],
  output logic signed [15:0] torque,
  output logic [15:0]       low_rumble,
  output logic [15:0]       high_rumble
);

  // Captured sample.
  logic signed [19:0] steer, speed, slip, wheel, prior, eng_in, coll_in, road_in, slope_in;
  logic grip, live;
  // Working registers.
  logic signed [19:0] light, acc, coll, road, damp, soft_stop, engine, sum, target;
  logic signed [15:0] smoothed;
  logic [15:0] clip_ex;
  logic clip_neg;
  // Serial restoring divider: quotient of ex*32768 over 32768 + 2*ex.
  logic [31:0] div_rem;
  logic [15:0] div_quo;
  logic [4:0]  div_cnt;
  logic [31:0] div_num;
  logic [17:0] div_den;
  logic [32:0] trial;

  logic signed [19:0] mul_a, mul_r;
  logic [16:0] mul_w;
  logic signed [20:0] sm_next;
  logic signed [23:0] spd_quot;
  logic [19:0] mag_sum, mag_w;
  logic signed [21:0] strength;
  logic [16:0] gain, minimum;

  assign gain = unit_w(regs[REG_GAIN]);
  assign minimum = unit_w(regs[REG_MINF]);
  assign stat.div_done = (div_cnt == 5'd0) && cmd.op == OP_DIV;
  assign trial = {div_rem, div_num[31]} - {15'd0, div_den};
  assign mag_sum = sum[19] ? 20'(-sum) : sum;
  assign mag_w = wheel[19] ? 20'(-wheel) : wheel;
  assign strength = $signed(22'(mag_w) * 22'd50 - 22'd1605632);
  // Excess of the clipped sum magnitude over 0.75.
  assign clip_ex = 16'((mag_sum > 20'd49152 ? 20'd49152 : mag_sum) - 20'd24576);
  // Speed times 32768/800 is speed*1024/25; the reciprocal 2^25/25 rounded up is exact
  // below full scale, and above it the result only errs upward into the clamp.
  assign spd_quot = 24'((36'(vehicle_speed) * 36'd1342178) >> 15);

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = acc;
    mul_w = 17'd0;
    case (cmd.op)
      OP_LIGHT: begin mul_a = slip; mul_w = unit_w(regs[REG_SLIDE]); end
      OP_GRIP:  begin mul_a = light; mul_w = 17'd11469; end
      OP_C1:    begin mul_a = steer; mul_w = 17'(speed); end
      OP_C2:    mul_w = unit_w(regs[REG_CENTER]);
      OP_C3:    mul_w = 17'(light);
      OP_COLL:  begin mul_a = coll_in; mul_w = unit_w(regs[REG_COLL]); end
      OP_ROAD1: begin mul_a = road_in; mul_w = 17'd21299; end
      OP_ROAD2: begin mul_a = slope_in; mul_w = 17'd11469; end
      OP_ROAD3: begin mul_a = road; mul_w = unit_w(regs[REG_ROAD]); end
      OP_DAMP:  begin mul_a = wheel - prior; mul_w = unit_w(regs[REG_DAMP]); end
      OP_SOFT:  begin
        mul_a = (strength <= 22'sd0) ? 20'sd0 :
                (strength > 22'sd32768 ? 20'sd32768 : 20'(strength));
        mul_w = SOFT_LOCK_WEIGHT;
      end
      OP_ENG1:  begin mul_a = eng_in; mul_w = 17'(speed); end
      OP_ENG2:  begin mul_a = engine; mul_w = ENGINE_WEIGHT; end
      OP_GAIN:  begin mul_a = acc; mul_w = gain; end
      OP_LOW1:  begin mul_a = coll[19] ? -coll : coll; mul_w = 17'd27853; end
      OP_LOW2:  begin mul_a = road[19] ? -road : road; mul_w = 17'd16384; end
      OP_LOW3, OP_HIGH3: mul_w = gain;
      OP_HIGH1: begin mul_a = slip; mul_w = 17'd13107; end
      OP_HIGH2: begin mul_a = engine[19] ? -engine : engine; mul_w = 17'd8192; end
      OP_SMOOTH: begin mul_a = target - 20'(smoothed); mul_w = 17'd14746; end
      default: ;
    endcase
  end

  assign mul_r = mulq(mul_a, mul_w);
  assign sm_next = 21'(smoothed) + 21'(mul_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed <= '0;
      div_cnt <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          live <= regs[REG_MODE][0] && car_active;
          steer <= clamp_s(26'(steer_position) * 26'sd8);
          speed <= (vehicle_speed <= 0) ? 20'sd0 : clamp_u(spd_quot);
          slip <= clamp_u((load_angle[15] ? -24'(load_angle) : 24'(load_angle)) * 24'sd32);
          grip <= grip_lost;
          wheel <= 20'(wheel_axis);
          prior <= 20'(prior_wheel_axis);
          eng_in <= 20'(engine_wave);
          coll_in <= clamp_s(26'(collision_push) * 26'sd512);
          road_in <= clamp_s(26'(road_bump) * 26'sd256);
          slope_in <= clamp_s(26'(cross_slope) * 26'sd512);
          soft_stop <= '0;
        end
        OP_LIGHT: light <= (20'sd32768 - mul_r < 0) ? 20'sd0 : 20'sd32768 - mul_r;
        OP_GRIP:  if (grip) light <= mul_r;
        OP_C1, OP_C2: acc <= mul_r;
        OP_C3:    acc <= -mul_r;
        OP_COLL:  coll <= mul_r;
        OP_ROAD1: road <= mul_r;
        OP_ROAD2: road <= road + mul_r;
        OP_ROAD3: road <= mul_r;
        OP_DAMP:  damp <= -mul_r;
        OP_SOFT: begin
          if (24'((steer[19] ? -steer : steer)) * 24'd10 > 24'd294912)
            soft_stop <= wheel > 0 ? -mul_r : mul_r;
          acc <= acc + coll + road + damp;
        end
        OP_ENG1:  engine <= mul_r;
        OP_ENG2:  engine <= 20'(mul_r);
        OP_SUM:   sum <= acc + soft_stop + engine;
        OP_CLIPSET: begin
          clip_neg <= sum[19];
          // The numerator bits above bit 15 stay below the divisor, so they preload
          // the remainder and 16 steps finish the quotient.
          div_rem <= {17'd0, clip_ex[15:1]};
          div_num <= {clip_ex[0], 31'd0};
          div_den <= 18'd32768 + {1'b0, clip_ex, 1'b0};
          div_cnt <= 5'd16;
          div_quo <= '0;
          if (mag_sum <= 20'd24576) div_cnt <= 5'd0;
        end
        OP_DIV: if (div_cnt != 0) begin
          div_cnt <= div_cnt - 5'd1;
          div_num <= div_num << 1;
          if (!trial[32]) begin
            div_rem <= trial[31:0];
            div_quo <= {div_quo[14:0], 1'b1};
          end else begin
            div_rem <= {div_rem[30:0], div_num[31]};
            div_quo <= {div_quo[14:0], 1'b0};
          end
        end
        OP_CLIPEND: begin
          if (mag_sum <= 20'd24576) acc <= sum;
          else if (20'd24576 + 20'(div_quo) > 20'd32768)
            acc <= clip_neg ? -20'sd32768 : 20'sd32768;
          else acc <= clip_neg ? -(20'sd24576 + 20'(div_quo)) : 20'sd24576 + 20'(div_quo);
        end
        OP_GAIN: acc <= regs[REG_MODE][1] ? -mul_r : mul_r;
        OP_TARGET: begin
          if (!live) target <= '0;
          else if (24'(acc) * 24'sd50 > 24'sd32768 && acc < $signed(20'(minimum)))
            target <= $signed(20'(minimum));
          else if (24'(acc) * 24'sd50 < -24'sd32768 && acc > -$signed(20'(minimum)))
            target <= -$signed(20'(minimum));
          else target <= acc;
        end
        OP_LOW1:  acc <= mul_r;
        OP_LOW2:  acc <= clamp_u(24'(acc + mul_r));
        OP_LOW3:  low_rumble <= live ? 16'(mul_r) : 16'd0;
        OP_HIGH1: acc <= (grip ? 20'sd18022 : 20'sd0) + mul_r;
        OP_HIGH2: acc <= clamp_u(24'(acc + mul_r));
        OP_HIGH3: high_rumble <= live ? 16'(mul_r) : 16'd0;
        OP_SMOOTH: smoothed <= (sm_next > 21'sd32767) ? 16'sd32767 :
                               (sm_next < -21'sd32768) ? -16'sd32768 : 16'(sm_next);
        default: ;
      endcase
    end
  end

  assign torque = smoothed;

endmodule

[sv/steering_force_feedback_mixer_unit.sv]
// Steering force feedback mixer: one vehicle sample in, one torque and two rumble
// levels out. Each transaction runs 25 steps of a shared 20x17 multiplier sequence
// with a divider state between them that passes straight on when the sum needs no
// soft clip and runs the serial divider when it does. The output register lets the
// next sample enter the cycle its result is taken.
// Configuration registers may be written while the unit is idle.
module steering_force_feedback_mixer_unit import sffm_pkg::*; (
  input logic clk,
  input logic rst,
  sffm_in_if.sink   in_ch,
  sffm_out_if.source out_ch,
  sffm_cfg_if.sink  cfg
);

`include "steering_force_feedback_mixer_unit_assert.svh"

  logic [15:0] regs [8];
  sffm_cmd_t  cmd;
  sffm_stat_t stat;

  assign cfg.ready = 1'b1;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs[REG_GAIN] <= 16'd18022;
      regs[REG_CENTER] <= 16'd26214;
      regs[REG_SLIDE] <= 16'd22938;
      regs[REG_COLL] <= 16'd24576;
      regs[REG_ROAD] <= 16'd8192;
      regs[REG_DAMP] <= 16'd6554;
      regs[REG_MINF] <= 16'd1966;
      regs[REG_MODE] <= 16'd1;
    end else if (cfg.valid) begin
      regs[cfg.index] <= (cfg.index == REG_MODE) ? {14'd0, cfg.data[1:0]} : cfg.data;
    end
  end

  sffm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .stat(stat), .cmd(cmd)
  );

  sffm_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .steer_position(in_ch.steer_position), .vehicle_speed(in_ch.vehicle_speed),
    .load_angle(in_ch.load_angle), .grip_lost(in_ch.grip_lost),
    .collision_push(in_ch.collision_push), .road_bump(in_ch.road_bump),
    .cross_slope(in_ch.cross_slope), .wheel_axis(in_ch.wheel_axis),
    .prior_wheel_axis(in_ch.prior_wheel_axis), .engine_wave(in_ch.engine_wave),
    .car_active(in_ch.car_active), .regs(regs),
    .torque(out_ch.torque), .low_rumble(out_ch.low_rumble),
    .high_rumble(out_ch.high_rumble)
  );

  `SFFM_ASSERT_NEXT(a_out_after_smooth, clk, rst, cmd.op == OP_SMOOTH, out_ch.valid, "no result after smoothing")
  `SFFM_ASSERT_IMP(a_no_load_while_busy, clk, rst, out_ch.valid && !out_ch.ready, !in_ch.ready, "accepted over pending result")
  `SFFM_ASSERT_IMP(a_rumble_bound, clk, rst, out_ch.valid, out_ch.low_rumble <= 16'd32768 && out_ch.high_rumble <= 16'd32768, "rumble above one")

endmodule
